// ===== hdl/rdcd_pkg.sv =====
// rdcd_pkg: shared codes, field widths and types for the deadlock cycle detector
// no dependencies; imported by the input and configuration channel interfaces and every rdcd module
package rdcd_pkg;

  localparam int FUNC_W     = 2;
  localparam int NODE_W     = 4;
  localparam int COUNT_W    = 5;
  localparam int CFG_ADDR_W = 2;

  // operation codes of an input transaction
  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CHECK  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PROCESS_COUNT  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RESOURCE_COUNT = 2'd1;

  localparam logic [COUNT_W-1:0] PROCESS_COUNT_RST  = 5'd2;
  localparam logic [COUNT_W-1:0] RESOURCE_COUNT_RST = 5'd2;

  typedef enum logic [1:0] {
    DFS_IDLE,
    DFS_ROOT,
    DFS_SCAN,
    DFS_POP
  } dfs_state_t;

  typedef struct packed {
    logic done;
    logic found;
  } dfs_status_t;

endpackage

// ===== hdl/rdcd_channels.sv =====
// rdcd channel interfaces: input item, result item and configuration write channels
// depends on rdcd_pkg for field widths
interface rdcd_in_if import rdcd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;

  modport source (output valid, output func, output from_node, output to_node, input ready);
  modport sink   (input valid, input func, input from_node, input to_node, output ready);
endinterface

interface rdcd_out_if ();
  logic valid;
  logic ready;
  logic deadlocked;
  logic bad_node;

  modport source (output valid, output deadlocked, output bad_node, input ready);
  modport sink   (input valid, input deadlocked, input bad_node, output ready);
endinterface

interface rdcd_cfg_if import rdcd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [COUNT_W-1:0]    wdata;

  modport source (output valid, output addr, output wdata, input ready);
  modport sink   (input valid, input addr, input wdata, output ready);
endinterface

// ===== hdl/rdcd_edge_mem.sv =====
// rdcd_edge_mem: adjacency matrix memory, one row per source node, registered read
// depends on rdcd_pkg; rows not yet written since reset read as zero via per-row valid bits
module rdcd_edge_mem import rdcd_pkg::*; #(
  parameter int MAX_NODES,
  localparam int NW = $clog2(MAX_NODES)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [NW-1:0]        wr_row,
  input  logic [NW-1:0]        wr_col,
  input  logic                 wr_set,
  input  logic                 rd_en,
  input  logic [NW-1:0]        rd_row,
  output logic [MAX_NODES-1:0] rd_data
);

  logic [MAX_NODES-1:0] mem [MAX_NODES];
  logic [MAX_NODES-1:0] row_valid_r;
  logic [MAX_NODES-1:0] rd_data_r;
  logic [MAX_NODES-1:0] col_bit;

  assign col_bit = {{(MAX_NODES-1){1'b0}}, 1'b1} << wr_col;
  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else if (wr_en) begin
      row_valid_r[wr_row] <= 1'b1;
    end
  end

  // first write to a row since reset lays down the whole row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      if (row_valid_r[wr_row]) begin
        mem[wr_row][wr_col] <= wr_set;
      end else begin
        mem[wr_row] <= wr_set ? col_bit : '0;
      end
    end
    if (rd_en) begin
      rd_data_r <= row_valid_r[rd_row] ? mem[rd_row] : '0;
    end
  end

endmodule

// ===== hdl/rdcd_dfs_engine.sv =====
// rdcd_dfs_engine: depth-first cycle search, one candidate column tested per cycle while scanning a row
// depends on rdcd_pkg; reads rows from rdcd_edge_mem, keeps the frame stack in a local memory
module rdcd_dfs_engine import rdcd_pkg::*; #(
  parameter int MAX_NODES,
  localparam int NW = $clog2(MAX_NODES),
  localparam int CW = $clog2(MAX_NODES + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [CW-1:0]        node_count,
  output dfs_status_t          status,
  output logic                 row_rd_en,
  output logic [NW-1:0]        row_rd_addr,
  input  logic [MAX_NODES-1:0] row_rd_data
);

  typedef struct packed {
    logic [NW-1:0] node;
    logic [CW-1:0] pos;
  } frame_t;

  dfs_state_t           state_r, state_nxt;
  logic [CW-1:0]        root_r, root_nxt;
  logic [NW-1:0]        cur_u_r, cur_u_nxt;
  logic [CW-1:0]        cur_v_r, cur_v_nxt;
  logic [CW-1:0]        depth_r, depth_nxt;
  logic [MAX_NODES-1:0] visited_r, visited_nxt;
  logic [MAX_NODES-1:0] on_path_r, on_path_nxt;

  frame_t               stack_mem [MAX_NODES];
  frame_t               stk_rd_data_r;
  frame_t               stk_wr_data;
  logic                 stk_wr_en;
  logic                 stk_rd_en;
  logic [NW-1:0]        stk_wr_addr;
  logic [NW-1:0]        stk_rd_addr;

  logic [NW-1:0]        v_idx;
  logic [NW-1:0]        root_idx;
  logic [CW-1:0]        depth_m1;
  logic [CW-1:0]        depth_m2;

  assign v_idx    = cur_v_r[NW-1:0];
  assign root_idx = root_r[NW-1:0];
  assign depth_m1 = depth_r - CW'(1);
  assign depth_m2 = depth_r - CW'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= DFS_IDLE;
      root_r    <= '0;
      depth_r   <= '0;
      visited_r <= '0;
      on_path_r <= '0;
    end else begin
      state_r   <= state_nxt;
      root_r    <= root_nxt;
      depth_r   <= depth_nxt;
      visited_r <= visited_nxt;
      on_path_r <= on_path_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_u_r <= cur_u_nxt;
    cur_v_r <= cur_v_nxt;
  end

  // frames below the current one; the current frame lives in cur_u_r / cur_v_r
  always_ff @(posedge clk) begin
    if (stk_wr_en) begin
      stack_mem[stk_wr_addr] <= stk_wr_data;
    end
    if (stk_rd_en) begin
      stk_rd_data_r <= stack_mem[stk_rd_addr];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    root_nxt    = root_r;
    cur_u_nxt   = cur_u_r;
    cur_v_nxt   = cur_v_r;
    depth_nxt   = depth_r;
    visited_nxt = visited_r;
    on_path_nxt = on_path_r;
    status      = '0;
    row_rd_en   = 1'b0;
    row_rd_addr = cur_u_r;
    stk_wr_en   = 1'b0;
    stk_wr_addr = depth_m1[NW-1:0];
    stk_wr_data = '{node: cur_u_r, pos: cur_v_r + CW'(1)};
    stk_rd_en   = 1'b0;
    stk_rd_addr = depth_m2[NW-1:0];

    unique case (state_r)
      DFS_IDLE: begin
        if (start) begin
          visited_nxt = '0;
          on_path_nxt = '0;
          depth_nxt   = '0;
          root_nxt    = '0;
          state_nxt   = DFS_ROOT;
        end
      end
      DFS_ROOT: begin
        if (root_r >= node_count) begin
          status.done = 1'b1;
          state_nxt   = DFS_IDLE;
        end else if (visited_r[root_idx]) begin
          root_nxt = root_r + CW'(1);
        end else begin
          visited_nxt[root_idx] = 1'b1;
          on_path_nxt[root_idx] = 1'b1;
          cur_u_nxt   = root_idx;
          cur_v_nxt   = '0;
          depth_nxt   = CW'(1);
          row_rd_en   = 1'b1;
          row_rd_addr = root_idx;
          state_nxt   = DFS_SCAN;
        end
      end
      DFS_SCAN: begin
        if (cur_v_r >= node_count) begin
          // row exhausted: retire the node from the path
          on_path_nxt[cur_u_r] = 1'b0;
          depth_nxt = depth_m1;
          if (depth_r == CW'(1)) begin
            root_nxt  = root_r + CW'(1);
            state_nxt = DFS_ROOT;
          end else begin
            stk_rd_en = 1'b1;
            state_nxt = DFS_POP;
          end
        end else if (row_rd_data[v_idx] && on_path_r[v_idx]) begin
          // back edge closes a cycle
          status.done  = 1'b1;
          status.found = 1'b1;
          state_nxt    = DFS_IDLE;
        end else if (row_rd_data[v_idx] && !visited_r[v_idx]) begin
          visited_nxt[v_idx] = 1'b1;
          on_path_nxt[v_idx] = 1'b1;
          stk_wr_en   = 1'b1;
          cur_u_nxt   = v_idx;
          cur_v_nxt   = '0;
          depth_nxt   = depth_r + CW'(1);
          row_rd_en   = 1'b1;
          row_rd_addr = v_idx;
        end else begin
          cur_v_nxt = cur_v_r + CW'(1);
        end
      end
      DFS_POP: begin
        cur_u_nxt   = stk_rd_data_r.node;
        cur_v_nxt   = stk_rd_data_r.pos;
        row_rd_en   = 1'b1;
        row_rd_addr = stk_rd_data_r.node;
        state_nxt   = DFS_SCAN;
      end
      default: begin
        state_nxt = DFS_IDLE;
      end
    endcase
  end

  a_path_in_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (on_path_r & ~visited_r) == '0)
    else $error("on-path node not marked visited");

  a_path_matches_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != DFS_IDLE) |-> ($countones(on_path_r) == int'(depth_r)))
    else $error("stack depth out of step with on-path marks");

  a_scan_has_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == DFS_SCAN || state_r == DFS_POP) |-> (depth_r != '0))
    else $error("scan or pop with an empty stack");

endmodule

// ===== hdl/rag_deadlock_cycle_detector.sv =====
// channel  | dir | handshake     | payload
// in_ch    | in  | valid / ready | func, from_node, to_node
// out_ch   | out | valid / ready | deadlocked, bad_node
// cfg_ch   | in  | valid / ready | addr, wdata (ready held high)
//
// add, remove and unused operations write their result straight into the one result register slot
// a check walks the graph of the active nodes with the single column tester in rdcd_dfs_engine,
// which tests one matrix bit per cycle while it scans a row
// in_ch.ready is low while a check runs and while an unread result is not being taken
// synchronous active-low reset clears the matrix (row valid bits) and the counts to 2
// depends on rdcd_pkg, rdcd_channels, rdcd_edge_mem and rdcd_dfs_engine
module rag_deadlock_cycle_detector import rdcd_pkg::*; #(
  parameter int MAX_NODES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  rdcd_cfg_if.sink    cfg_ch,
  rdcd_in_if.sink     in_ch,
  rdcd_out_if.source  out_ch
);

  localparam int NW    = $clog2(MAX_NODES);
  localparam int CW    = $clog2(MAX_NODES + 1);
  localparam int SUM_W = COUNT_W + 1;
  localparam int CMP_W = (CW > SUM_W) ? CW : SUM_W;
  localparam int XW    = (CW > NODE_W) ? CW : NODE_W;

  logic [COUNT_W-1:0]   proc_count_r;
  logic [COUNT_W-1:0]   res_count_r;
  logic [CMP_W-1:0]     count_sum;
  logic [CW-1:0]        node_count;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_dead_r, out_dead_nxt;
  logic                 out_bad_r, out_bad_nxt;
  logic                 query_busy_r, query_busy_nxt;

  logic                 in_accept;
  logic                 range_bad;
  logic                 edge_wr_en;
  logic                 dfs_start;
  dfs_status_t          dfs_st;
  logic                 row_rd_en;
  logic [NW-1:0]        row_rd_addr;
  logic [MAX_NODES-1:0] row_rd_data;

  // active node count, clamped to capacity
  assign count_sum  = CMP_W'(proc_count_r) + CMP_W'(res_count_r);
  assign node_count = (count_sum > CMP_W'(MAX_NODES)) ? CW'(MAX_NODES) : CW'(count_sum);

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proc_count_r <= PROCESS_COUNT_RST;
      res_count_r  <= RESOURCE_COUNT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.addr)
        CFG_PROCESS_COUNT:  proc_count_r <= cfg_ch.wdata;
        CFG_RESOURCE_COUNT: res_count_r  <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !query_busy_r && (!out_valid_r || out_ch.ready);
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign range_bad   = (XW'(in_ch.from_node) >= XW'(node_count)) ||
                       (XW'(in_ch.to_node) >= XW'(node_count));

  always_comb begin
    edge_wr_en     = 1'b0;
    dfs_start      = 1'b0;
    query_busy_nxt = query_busy_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_dead_nxt   = out_dead_r;
    out_bad_nxt    = out_bad_r;

    if (in_accept) begin
      unique case (in_ch.func) inside
        FUNC_ADD, FUNC_REMOVE: begin
          edge_wr_en    = !range_bad;
          out_valid_nxt = 1'b1;
          out_dead_nxt  = 1'b0;
          out_bad_nxt   = range_bad;
        end
        FUNC_CHECK: begin
          dfs_start      = 1'b1;
          query_busy_nxt = 1'b1;
        end
        default: begin
          out_valid_nxt = 1'b1;
          out_dead_nxt  = 1'b0;
          out_bad_nxt   = 1'b0;
        end
      endcase
    end

    if (dfs_st.done) begin
      query_busy_nxt = 1'b0;
      out_valid_nxt  = 1'b1;
      out_dead_nxt   = dfs_st.found;
      out_bad_nxt    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      query_busy_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      query_busy_r <= query_busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_dead_r <= out_dead_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.deadlocked = out_dead_r;
  assign out_ch.bad_node   = out_bad_r;

  rdcd_edge_mem #(
    .MAX_NODES (MAX_NODES)
  ) u_edge_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (edge_wr_en),
    .wr_row  (NW'(in_ch.from_node)),
    .wr_col  (NW'(in_ch.to_node)),
    .wr_set  (in_ch.func == FUNC_ADD),
    .rd_en   (row_rd_en),
    .rd_row  (row_rd_addr),
    .rd_data (row_rd_data)
  );

  rdcd_dfs_engine #(
    .MAX_NODES (MAX_NODES)
  ) u_dfs_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (dfs_start),
    .node_count  (node_count),
    .status      (dfs_st),
    .row_rd_en   (row_rd_en),
    .row_rd_addr (row_rd_addr),
    .row_rd_data (row_rd_data)
  );

  a_done_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    dfs_st.done |-> query_busy_r)
    else $error("search finished with no check outstanding");

  a_done_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    dfs_st.done |-> !out_valid_r)
    else $error("search result would overwrite an unread result");

  a_check_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_ch.func == FUNC_CHECK) |=> (query_busy_r && !out_valid_r))
    else $error("check transaction did not start a search");

endmodule
